/* hw/rtl/frt_pkg.sv */
// ----------------------------------------------------------------------------
// frt_pkg
// shared types and constants of the fragment reassembly tracker
// ----------------------------------------------------------------------------
package frt_pkg;

	localparam int NUM_SESSIONS = 16;
	localparam int BUFFER_BYTES = 2048;

	localparam int SLOT_W = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;
	localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);
	localparam int SUM_W  = ((LEN_W > 12) ? LEN_W : 12) + 1;
	localparam int NSEQ_W = 8;
	localparam int TIME_W = 32;
	localparam int TMO_W  = 16;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MULTI_MODE = 2'd0,
		CFG_TIMEOUT    = 2'd1
	} cfg_reg_t;

	localparam logic             MODE_RESET    = 1'b1;
	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd5000;

	typedef enum logic [2:0] {
		ST_WAIT     = 3'd0,
		ST_DONE     = 3'd1,
		ST_NOSLOT   = 3'd2,
		ST_SEQ      = 3'd3,
		ST_TIMEOUT  = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	typedef struct packed {
		logic [15:0]       src_id;
		logic [6:0]        seq_num;
		logic              last_flag;
		logic [11:0]       frag_len;
		logic [TIME_W-1:0] now_ms;
	} frt_in_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  slot_index;
		logic [11:0] write_offset;
		logic [11:0] copy_len;
		logic        skip_first_byte;
		logic [11:0] reasm_len;
	} frt_out_t;

	typedef struct packed {
		logic [15:0]       src_id;
		logic [6:0]        seq_num;
		logic              last_flag;
		logic [TIME_W-1:0] now_ms;
		logic              seq_zero;
		logic              len_zero;
		logic              skip;
		logic [11:0]       cnt;
	} frt_job_t;

endpackage

/* hw/rtl/fragment_reassembly_tracker.sv */
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// session table tracker for reassembly of fragmented mesh packets
// ----------------------------------------------------------------------------
// One result word per fragment word. A fragment passes the session engine
// through dequeue, table lookup, state read and checks, and table update
// when multi mode is off, its source matches an active session or a free
// slot exists; when all NUM_SESSIONS slots are busy and none matches, a scan
// for the oldest stamp reads one slot per cycle, and if it finds no stamp
// below all ones the result is no-slot. A two-word queue in front takes new
// fragments while the engine works, and the result register holds a finished
// word while the next one is processed. The session table is cleared at reset.
module fragment_reassembly_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  frt_pkg::frt_in_t              in_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output frt_pkg::frt_out_t             out_word,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [frt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import frt_pkg::*;

	logic             multi_mode_q;
	logic [TMO_W-1:0] timeout_q;
	logic             job_valid;
	logic             job_pop;
	frt_job_t         job_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multi_mode_q <= MODE_RESET;
			timeout_q    <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MULTI_MODE: multi_mode_q <= cfg_data[0];
				CFG_TIMEOUT:    timeout_q    <= TMO_W'(cfg_data);
				default:        multi_mode_q <= multi_mode_q;
			endcase
		end
	end

	frt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job_word  (job_word)
	);

	frt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.multi_mode (multi_mode_q),
		.timeout_ms (timeout_q),
		.job_valid  (job_valid),
		.job_pop    (job_pop),
		.job_word   (job_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word)
	);

endmodule

/* hw/rtl/frt_front.sv */
// ----------------------------------------------------------------------------
// frt_front
// accepts fragment words, classifies them and queues them for the engine
// ----------------------------------------------------------------------------
module frt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  frt_pkg::frt_in_t  in_word,
	output logic              job_valid,
	input  logic              job_pop,
	output frt_pkg::frt_job_t job_word
);
	import frt_pkg::*;

	frt_job_t           q_mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;
	frt_job_t           job_new;
	logic               push;
	logic               pop;

	// classify
	always_comb begin
		job_new.src_id    = in_word.src_id;
		job_new.seq_num   = in_word.seq_num;
		job_new.last_flag = in_word.last_flag;
		job_new.now_ms    = in_word.now_ms;
		job_new.seq_zero  = (in_word.seq_num == 7'd0);
		job_new.len_zero  = (in_word.frag_len == 12'd0);
		job_new.skip      = !job_new.seq_zero;
		job_new.cnt       = job_new.seq_zero ? in_word.frag_len
			: (in_word.frag_len - 12'd1);
	end

	assign in_stall  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign push      = in_valid && !in_stall;
	assign job_valid = (count_q != '0);
	assign pop       = job_pop && job_valid;
	assign job_word  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= job_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/frt_back.sv */
// ----------------------------------------------------------------------------
// frt_back
// session engine: slot lookup, oldest-stamp scan, checks and table update
// ----------------------------------------------------------------------------
module frt_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     multi_mode,
	input  logic [frt_pkg::TMO_W-1:0] timeout_ms,
	input  logic                     job_valid,
	output logic                     job_pop,
	input  frt_pkg::frt_job_t        job_word,
	output logic                     out_valid,
	input  logic                     out_stall,
	output frt_pkg::frt_out_t        out_word
);
	import frt_pkg::*;

	typedef enum logic [4:0] {
		BK_IDLE   = 5'b00001,
		BK_LOOKUP = 5'b00010,
		BK_SCAN   = 5'b00100,
		BK_READ   = 5'b01000,
		BK_EXEC   = 5'b10000
	} bk_state_t;

	bk_state_t state_q;

	logic              sess_active_q [NUM_SESSIONS];
	logic [15:0]       sess_source_q [NUM_SESSIONS];
	logic [LEN_W-1:0]  sess_length_q [NUM_SESSIONS];
	logic [NSEQ_W-1:0] sess_next_q   [NUM_SESSIONS];
	logic [TIME_W-1:0] sess_stamp_q  [NUM_SESSIONS];

	frt_job_t          job_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] scan_idx_q;
	logic [TIME_W-1:0] oldest_q;
	logic              found_q;
	logic              noslot_q;

	logic [LEN_W-1:0]  off_q;
	logic [SUM_W-1:0]  sum_q;
	logic [NSEQ_W-1:0] next_inc_q;
	logic              seq_bad_q;
	logic              late_q;

	logic              out_valid_q;
	frt_out_t          out_word_q;

	logic              match_any;
	logic              free_any;
	logic [SLOT_W-1:0] match_idx;
	logic [SLOT_W-1:0] free_idx;
	logic [SLOT_W-1:0] rd_addr;
	logic [TIME_W-1:0] rd_stamp;
	logic              scan_hit;
	logic              scan_last;

	logic [NSEQ_W-1:0] eff_next;
	logic [LEN_W-1:0]  eff_len;
	logic [TIME_W-1:0] eff_stamp;
	logic [TIME_W-1:0] age;

	logic              res_free;
	logic              exec_fire;
	logic              err_ovf;
	logic              success;
	status_t           res_status;
	frt_out_t          res_word;

	// parallel match over the table
	always_comb begin
		match_any = 1'b0;
		free_any  = 1'b0;
		match_idx = '0;
		free_idx  = '0;
		for (int i = NUM_SESSIONS - 1; i >= 0; i--) begin
			if (sess_active_q[i] && (sess_source_q[i] == job_q.src_id)) begin
				match_any = 1'b1;
				match_idx = SLOT_W'(i);
			end
			if (!sess_active_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign rd_addr   = (state_q == BK_SCAN) ? scan_idx_q : slot_q;
	assign rd_stamp  = sess_stamp_q[rd_addr];
	assign scan_hit  = (rd_stamp < oldest_q);
	assign scan_last = (scan_idx_q == SLOT_W'(NUM_SESSIONS - 1));

	// a sequence 0 fragment sees a freshly restarted session
	assign eff_next  = job_q.seq_zero ? '0 : sess_next_q[slot_q];
	assign eff_len   = job_q.seq_zero ? '0 : sess_length_q[slot_q];
	assign eff_stamp = job_q.seq_zero ? job_q.now_ms : rd_stamp;
	assign age       = job_q.now_ms - eff_stamp;

	assign res_free  = !out_valid_q || !out_stall;
	assign exec_fire = (state_q == BK_EXEC) && res_free;
	assign job_pop   = (state_q == BK_IDLE) && job_valid;

	always_comb begin
		err_ovf = (job_q.len_zero && !job_q.seq_zero) || (sum_q > SUM_W'(BUFFER_BYTES));
		success = 1'b0;
		if (noslot_q) begin
			res_status = ST_NOSLOT;
		end else if (seq_bad_q) begin
			res_status = ST_SEQ;
		end else if (late_q) begin
			res_status = ST_TIMEOUT;
		end else if (err_ovf) begin
			res_status = ST_OVERFLOW;
		end else if (job_q.last_flag) begin
			res_status = ST_DONE;
			success    = 1'b1;
		end else begin
			res_status = ST_WAIT;
			success    = 1'b1;
		end
		res_word                 = '0;
		res_word.status          = res_status;
		res_word.slot_index      = noslot_q ? 4'd0 : 4'(slot_q);
		if (success) begin
			res_word.write_offset    = 12'(off_q);
			res_word.copy_len        = job_q.cnt;
			res_word.skip_first_byte = job_q.skip;
			res_word.reasm_len       = job_q.last_flag ? 12'(sum_q) : 12'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job_word;
		end
		if (state_q == BK_READ) begin
			off_q      <= eff_len;
			sum_q      <= SUM_W'(eff_len) + SUM_W'(job_q.cnt);
			next_inc_q <= eff_next + 1'b1;
			seq_bad_q  <= ({1'b0, job_q.seq_num} != eff_next);
			late_q     <= (age > {{(TIME_W-TMO_W){1'b0}}, timeout_ms});
		end
		if (exec_fire) begin
			out_word_q <= res_word;
		end
	end

	// control and session table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			slot_q      <= '0;
			scan_idx_q  <= '0;
			oldest_q    <= '1;
			found_q     <= 1'b0;
			noslot_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_SESSIONS; i++) begin
				sess_active_q[i] <= 1'b0;
				sess_source_q[i] <= '0;
				sess_length_q[i] <= '0;
				sess_next_q[i]   <= '0;
				sess_stamp_q[i]  <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (job_valid) begin
						noslot_q <= 1'b0;
						state_q  <= BK_LOOKUP;
					end
				end
				BK_LOOKUP: begin
					if (!multi_mode) begin
						slot_q  <= '0;
						state_q <= BK_READ;
					end else if (match_any) begin
						slot_q  <= match_idx;
						state_q <= BK_READ;
					end else if (free_any) begin
						slot_q  <= free_idx;
						state_q <= BK_READ;
					end else begin
						scan_idx_q <= '0;
						oldest_q   <= '1;
						found_q    <= 1'b0;
						state_q    <= BK_SCAN;
					end
				end
				BK_SCAN: begin
					if (scan_hit) begin
						oldest_q <= rd_stamp;
						slot_q   <= scan_idx_q;
						found_q  <= 1'b1;
					end
					scan_idx_q <= scan_idx_q + 1'b1;
					if (scan_last) begin
						if (found_q || scan_hit) begin
							state_q <= BK_READ;
						end else begin
							noslot_q <= 1'b1;
							state_q  <= BK_EXEC;
						end
					end
				end
				BK_READ: begin
					state_q <= BK_EXEC;
				end
				BK_EXEC: begin
					if (res_free) begin
						out_valid_q <= 1'b1;
						state_q     <= BK_IDLE;
						if (!noslot_q) begin
							if (job_q.seq_zero) begin
								sess_source_q[slot_q] <= job_q.src_id;
							end
							if (success) begin
								sess_length_q[slot_q] <= LEN_W'(sum_q);
								sess_next_q[slot_q]   <= next_inc_q;
							end else if (job_q.seq_zero) begin
								sess_length_q[slot_q] <= '0;
								sess_next_q[slot_q]   <= '0;
							end
							if (success || job_q.seq_zero) begin
								sess_stamp_q[slot_q] <= job_q.now_ms;
							end
							if (!success || job_q.last_flag) begin
								sess_active_q[slot_q] <= 1'b0;
							end else if (job_q.seq_zero) begin
								sess_active_q[slot_q] <= 1'b1;
							end
						end
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_done_total: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_word_q.status == ST_DONE) |->
		(out_word_q.reasm_len == 12'(out_word_q.write_offset + out_word_q.copy_len)))
		else $error("complete word total length differs from offset plus copy length");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_word_q.status == ST_NOSLOT || out_word_q.status == ST_SEQ ||
		out_word_q.status == ST_TIMEOUT || out_word_q.status == ST_OVERFLOW)) |->
		(out_word_q.copy_len == 12'd0 && out_word_q.reasm_len == 12'd0 &&
		out_word_q.write_offset == 12'd0 && !out_word_q.skip_first_byte))
		else $error("error word carries copy fields");

	a_close_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && !noslot_q && res_status != ST_WAIT) |=>
		!sess_active_q[$past(slot_q)])
		else $error("slot still active after completion or error");

endmodule

/* test/fragment_reassembly_tracker_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_test
// self-checking bench for the fragment reassembly session tracker
// ----------------------------------------------------------------------------
// Fragment words are queued by the sequencer below and driven by a clocked
// driver. Each accepted word goes through a session table tracker kept in
// the bench, which predicts the result word. A clocked monitor checks every
// result against the oldest prediction. A directed burst fills the table,
// hits the no-slot, overflow, timeout and sequence cases, then eight random
// phases run interleaved fragment streams with some noise under different
// register settings and idle patterns.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_test;
	import frt_pkg::*;

	localparam int                   SETTLE_CYCLES = 40;
	localparam int                   PHASE_WORDS   = 165;
	localparam int                   SRC_POOL      = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
	localparam logic [31:0]          TIME_TOP      = 32'hFFFF_FFFF;

	localparam int PH_MODE [8]    = '{1, 1, 0, 1, 0, 1, 0, 1};
	localparam int PH_TMO [8]     = '{65535, 5000, 5000, 0, 65535, 300, 0, 5000};
	localparam int PH_SEND [8]    = '{0, 50, 0, 23, 0, 50, 0, 23};
	localparam int PH_RECV [8]    = '{0, 0, 50, 23, 0, 0, 50, 23};
	localparam int PH_STREAMS [8] = '{4, 4, 1, 4, 3, 6, 1, 8};

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	frt_in_t  in_word = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	frt_out_t out_word;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// session table as the tracker should hold it
	logic              slot_busy [NUM_SESSIONS];
	logic [15:0]       slot_owner [NUM_SESSIONS];
	logic [11:0]       slot_fill [NUM_SESSIONS];
	logic [7:0]        slot_expect_seq [NUM_SESSIONS];
	logic [31:0]       slot_last_ms [NUM_SESSIONS];
	logic              lookup_on = MODE_RESET;
	logic [TMO_W-1:0]  max_age_ms = TIMEOUT_RESET;

	frt_in_t  pending_frags[$];
	frt_out_t expected_results[$];
	frt_out_t want_word;
	logic [15:0] src_pool [SRC_POOL];
	logic [31:0] clock_ms;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int frags_sent = 0;
	int settings_used = 0;
	int status_count [6];

	fragment_reassembly_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic frt_out_t track_fragment(input frt_in_t f);
		frt_out_t    r;
		int          s;
		logic [31:0] oldest;
		logic [31:0] age;
		logic [11:0] off;
		logic [11:0] cnt;
		logic [12:0] sum;
		logic        skip;
		r = '0;
		s = -1;
		if (!lookup_on) begin
			s = 0;
		end else begin
			for (int i = 0; i < NUM_SESSIONS; i++)
				if (s < 0 && slot_busy[i] && slot_owner[i] == f.src_id)
					s = i;
			for (int i = 0; i < NUM_SESSIONS; i++)
				if (s < 0 && !slot_busy[i])
					s = i;
			if (s < 0) begin
				oldest = TIME_TOP;
				for (int i = 0; i < NUM_SESSIONS; i++)
					if (slot_last_ms[i] < oldest) begin
						oldest = slot_last_ms[i];
						s = i;
					end
			end
		end
		if (s < 0) begin
			r.status = ST_NOSLOT;
			return r;
		end
		r.slot_index = s[3:0];
		if (f.seq_num == 7'd0) begin
			slot_busy[s] = 1'b1;
			slot_owner[s] = f.src_id;
			slot_fill[s] = '0;
			slot_expect_seq[s] = '0;
			slot_last_ms[s] = f.now_ms;
		end
		if ({1'b0, f.seq_num} != slot_expect_seq[s]) begin
			slot_busy[s] = 1'b0;
			r.status = ST_SEQ;
			return r;
		end
		age = f.now_ms - slot_last_ms[s];
		if (age > {16'd0, max_age_ms}) begin
			slot_busy[s] = 1'b0;
			r.status = ST_TIMEOUT;
			return r;
		end
		off = slot_fill[s];
		if (f.seq_num == 7'd0) begin
			cnt = f.frag_len;
			skip = 1'b0;
		end else begin
			if (f.frag_len == 12'd0) begin
				slot_busy[s] = 1'b0;
				r.status = ST_OVERFLOW;
				return r;
			end
			cnt = f.frag_len - 12'd1;
			skip = 1'b1;
		end
		sum = {1'b0, off} + {1'b0, cnt};
		if (sum > BUFFER_BYTES) begin
			slot_busy[s] = 1'b0;
			r.status = ST_OVERFLOW;
			return r;
		end
		slot_fill[s] = sum[11:0];
		slot_expect_seq[s] = slot_expect_seq[s] + 8'd1;
		slot_last_ms[s] = f.now_ms;
		r.write_offset = off;
		r.copy_len = cnt;
		r.skip_first_byte = skip;
		if (f.last_flag) begin
			slot_busy[s] = 1'b0;
			r.status = ST_DONE;
			r.reasm_len = sum[11:0];
		end else begin
			r.status = ST_WAIT;
		end
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(track_fragment(in_word));
				frags_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_frags.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_word <= pending_frags.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected: status %0d slot %0d",
						out_word.status, out_word.slot_index);
					mismatches++;
				end else begin
					want_word = expected_results.pop_front();
					if (want_word.status <= ST_OVERFLOW)
						status_count[want_word.status]++;
					if (out_word.status !== want_word.status) begin
						$error("status: expected %0d, got %0d", want_word.status,
							out_word.status);
						mismatches++;
					end
					if (out_word.slot_index !== want_word.slot_index) begin
						$error("slot_index: expected %0d, got %0d", want_word.slot_index,
							out_word.slot_index);
						mismatches++;
					end
					if (out_word.write_offset !== want_word.write_offset) begin
						$error("write_offset: expected %0d, got %0d", want_word.write_offset,
							out_word.write_offset);
						mismatches++;
					end
					if (out_word.copy_len !== want_word.copy_len) begin
						$error("copy_len: expected %0d, got %0d", want_word.copy_len,
							out_word.copy_len);
						mismatches++;
					end
					if (out_word.skip_first_byte !== want_word.skip_first_byte) begin
						$error("skip_first_byte: expected %0d, got %0d",
							want_word.skip_first_byte, out_word.skip_first_byte);
						mismatches++;
					end
					if (out_word.reasm_len !== want_word.reasm_len) begin
						$error("reasm_len: expected %0d, got %0d", want_word.reasm_len,
							out_word.reasm_len);
						mismatches++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MULTI_MODE)
			lookup_on = val[0];
		else if (idx == CFG_TIMEOUT)
			max_age_ms = val;
	endtask

	task automatic wait_quiet();
		while (pending_frags.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_frag(input logic [15:0] src, input int seq, input logic last,
			input int len, input logic [31:0] now);
		frt_in_t w;
		w.src_id = src;
		w.seq_num = seq[6:0];
		w.last_flag = last;
		w.frag_len = len[11:0];
		w.now_ms = now;
		pending_frags.push_back(w);
	endtask

	// interleaved fragment streams, a few of them very long, with some noise
	task automatic queue_traffic(input int n, input int streams);
		logic [15:0] s_src [8];
		int          s_seq [8];
		int          s_left [8];
		logic        s_long [8];
		int          k;
		int          p;
		int          len;
		logic [15:0] src;
		logic [6:0]  seq;
		logic        last;
		for (k = 0; k < 8; k++)
			s_left[k] = 0;
		for (k = 0; k < n; k++) begin
			p = $urandom_range(streams - 1);
			if (s_left[p] == 0) begin
				s_src[p] = src_pool[$urandom_range(SRC_POOL - 1)];
				s_seq[p] = 0;
				s_long[p] = ($urandom_range(79) == 0);
				s_left[p] = s_long[p] ? 130 : $urandom_range(1, 8);
			end
			if ($urandom_range(3) != 0)
				clock_ms += $urandom_range(1, 30);
			src = s_src[p];
			seq = s_seq[p][6:0];
			last = (s_left[p] == 1);
			if (s_long[p])
				len = $urandom_range(1, 2);
			else if (seq == 7'd0)
				len = $urandom_range(0, 400);
			else
				len = $urandom_range(1, 400);
			if (!s_long[p] && $urandom_range(99) < 12) begin
				case ($urandom_range(5))
					0: begin
						seq = 7'($urandom_range(127));
						last = 1'($urandom_range(1));
					end
					1: len = 0;
					2: len = $urandom_range(1500, BUFFER_BYTES);
					3: src = 16'($urandom_range(16'hFFFF));
					4: clock_ms += $urandom_range(4000, 70000);
					default: clock_ms = $urandom;
				endcase
			end
			add_frag(src, seq, last, len, clock_ms);
			s_seq[p]++;
			s_left[p]--;
		end
	endtask

	initial begin
		#8_000_000;
		$display("fragment_reassembly_tracker_test: done, errors");
		$finish;
	end

	initial begin
		for (int i = 0; i < NUM_SESSIONS; i++) begin
			slot_busy[i] = 1'b0;
			slot_owner[i] = '0;
			slot_fill[i] = '0;
			slot_expect_seq[i] = '0;
			slot_last_ms[i] = '0;
		end
		for (int i = 0; i < 6; i++)
			status_count[i] = 0;
		src_pool[0] = 16'h0000;
		src_pool[1] = 16'hFFFF;
		for (int i = 2; i < SRC_POOL; i++)
			src_pool[i] = 16'($urandom_range(16'hFFFF));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// fill every slot at the top of time, then the no-slot and error cases
		for (int i = 0; i < NUM_SESSIONS; i++)
			add_frag((i == 0) ? 16'h0000 : (i == NUM_SESSIONS - 1) ? 16'hFFFF :
				16'(16'h0100 + i),
				0, 1'b0, (i == 0) ? 0 : (i == 1) ? BUFFER_BYTES : 5, TIME_TOP);
		add_frag(16'h5555, 0, 1'b0, 7, TIME_TOP);
		add_frag(16'hAAAA, 5, 1'b1, 9, TIME_TOP);
		add_frag(16'hFFFF, 1, 1'b0, 1, 32'd5);
		add_frag(16'h0101, 1, 1'b0, 2, 32'd5);
		add_frag(16'h0000, 1, 1'b0, 0, 32'd5);
		add_frag(16'h0102, 3, 1'b0, 4, 32'd5);
		add_frag(16'h0103, 1, 1'b0, 4, 32'd5000);
		add_frag(16'h0104, 1, 1'b1, 2044, 32'd4999);
		add_frag(16'h7E7E, 0, 1'b1, BUFFER_BYTES, 32'd4999);
		wait_quiet();
		settings_used++;
		clock_ms = 32'd5000;

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_MULTI_MODE, CFG_DATA_W'(PH_MODE[ph]));
			write_reg(CFG_TIMEOUT, CFG_DATA_W'(PH_TMO[ph]));
			if (ph == 3)
				write_reg(CFG_SPARE_IDX, 16'hFFFF);
			if (ph == 4)
				clock_ms = 32'hFFFF_F000;
			settings_used++;
			send_idle_pct = PH_SEND[ph];
			recv_stall_pct = PH_RECV[ph];
			queue_traffic(PHASE_WORDS, PH_STREAMS[ph]);
			wait_quiet();
		end

		$display("%0d fragment words checked over %0d register settings and four idle patterns",
			frags_sent, settings_used);
		$display("results: waiting %0d, complete %0d, no slot %0d, %s %0d, timeout %0d, %s %0d",
			status_count[ST_WAIT], status_count[ST_DONE], status_count[ST_NOSLOT],
			"sequence", status_count[ST_SEQ], status_count[ST_TIMEOUT],
			"overflow", status_count[ST_OVERFLOW]);
		if (mismatches == 0)
			$display("fragment_reassembly_tracker_test: done, clean");
		else
			$display("fragment_reassembly_tracker_test: done, errors");
		$finish;
	end

endmodule
